// ----- src/trial_division_prime_test_core_macros.svh -----
// Assertion helpers used by the trial division core
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define TDPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tdpt_pkg.sv -----
package tdpt_pkg;

  // Width of the number port
  localparam int unsigned NUMBER_W = 32;

  // Status of the serial remainder unit
  typedef struct packed {
    logic busy;  // remainder in progress
    logic done;  // remainder ready this cycle
    logic zero;  // remainder is zero, valid with done
  } rem_stat_t;

endpackage

// ----- src/trial_division_prime_test_core.sv -----
// Flow: ST_IDLE takes a word, then ST_SETUP rejects values of 1 or less and values with the
//   sign bit set; otherwise ST_TEST and ST_WAIT run the serial remainder for each divisor
//   tried, from 2 up to the first factor or up to floor(sqrt(number)), and ST_DONE follows.
// Input stalls while a word is under test: a new word is taken only once the last leaves ST_DONE.
// A finished result waits in the output register while the next word is accepted.
// Reset (rst_ni low, asynchronous) empties the core and the output register.
`include "trial_division_prime_test_core_macros.svh"

module trial_division_prime_test_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tdpt_pkg::NUMBER_W-1:0] number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_prime_o
);

  localparam int unsigned VB = VALUE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TEST,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [VB-1:0]       n_q;
  logic [VB-1:0]       d_q;
  logic [VB:0]         sq_q;
  logic                verdict_q;
  logic                out_valid_q;
  logic                is_prime_q;
  logic                sq_over;
  logic                start_rem;
  tdpt_pkg::rem_stat_t stat;

  // Stop once d * d passes n
  assign sq_over   = (sq_q > {1'b0, n_q});
  assign start_rem = (state_q == ST_TEST) && !sq_over;

  // Serial remainder n mod d
  tdpt_rem #(
    .W (VB)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_rem),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .stat_o     (stat)
  );

  // Sequence the divisor search and hold the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      d_q         <= '0;
      sq_q        <= '0;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
      is_prime_q  <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q     <= number_i[VB-1:0];
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          d_q  <= VB'(2);
          sq_q <= (VB + 1)'(4);
          if (n_q[VB-1] || (n_q <= VB'(1))) begin
            verdict_q <= 1'b0;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (sq_over) begin
            verdict_q <= 1'b1;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (stat.done) begin
            if (stat.zero) begin
              verdict_q <= 1'b0;
              state_q   <= ST_DONE;
            end else begin
              // Advance to d + 1; (d + 1)^2 = d^2 + 2d + 1
              d_q     <= d_q + 1'b1;
              sq_q    <= sq_q + {d_q, 1'b1};
              state_q <= ST_TEST;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            is_prime_q  <= verdict_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  `TDPT_ASSERT(a_done_in_wait, stat.done |-> (state_q == ST_WAIT), "remainder done outside wait")
  `TDPT_ASSERT(a_wait_has_rem, (state_q == ST_WAIT) |-> (stat.busy || stat.done), "idle rem unit")
  `TDPT_ASSERT(a_neg_not_prime, (state_q == ST_DONE && n_q[VB-1]) |-> !verdict_q, "negative prime")
  `TDPT_ASSERT(a_sq_above_d, (state_q == ST_TEST) |-> (sq_q > {1'b0, d_q}), "square below divisor")
  `TDPT_ASSERT_NEXT(a_done_pulse, stat.done, !stat.done, "remainder done held two cycles")

endmodule

// ----- src/tdpt_rem.sv -----
module tdpt_rem #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        dividend_i,
  input  logic [W-1:0]        divisor_i,
  output tdpt_pkg::rem_stat_t stat_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  shift_q;
  logic [W:0]    rem_q;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       fits;

  // Bring down the next dividend bit and try one subtract
  assign trial = {rem_q[W-1:0], shift_q[W-1]};
  assign fits  = (trial >= {1'b0, divisor_i});
  assign diff  = trial - {1'b0, divisor_i};

  // Track the run, one dividend bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift the dividend out and the partial remainder along
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[W-2:0], 1'b0};
      rem_q   <= fits ? diff : trial;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

endmodule

// ----- verif/tdpt_prime_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the trial division core, predicts the prime flag of
// every accepted word and compares it with the results in order.
module tdpt_prime_checker #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [tdpt_pkg::NUMBER_W-1:0] number_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          is_prime_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   primes_o
);

  // One word under test and the flag it should produce
  typedef struct packed {
    logic [tdpt_pkg::NUMBER_W-1:0] number;
    logic                          prime;
  } prime_verdict_t;

  prime_verdict_t verdicts_q [$];
  prime_verdict_t head;
  int unsigned    mismatches = 0;
  int unsigned    checked    = 0;
  int unsigned    primes     = 0;

  // Trial division on the low VALUE_BITS bits read as a signed value
  function automatic logic predict_prime(input logic [tdpt_pkg::NUMBER_W-1:0] word);
    logic [63:0] value;
    logic [63:0] divisor;
    value = 64'(word) & ((64'd1 << VALUE_BITS) - 64'd1);
    if (value[VALUE_BITS-1]) return 1'b0;
    if (value <= 64'd1) return 1'b0;
    for (divisor = 64'd2; divisor * divisor <= value; divisor++) begin
      if (value % divisor == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Queue each accepted word, then check each accepted result against the oldest
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        verdicts_q.push_back('{number: number_i, prime: predict_prime(number_i)});
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_q.size() == 0) begin
          report_mismatch($sformatf("is_prime=%b with no word outstanding", is_prime_i));
        end else begin
          head = verdicts_q.pop_front();
          checked++;
          if (head.prime) primes++;
          if (is_prime_i !== head.prime) begin
            report_mismatch($sformatf("word %0d (0x%08h): is_prime=%b, want %b",
                                      $signed(head.number), head.number, is_prime_i,
                                      head.prime));
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= verdicts_q.size();
      checked_o    <= checked;
      primes_o     <= primes;
    end
  end

endmodule

// ----- verif/tb_trial_division_prime_test_core.sv -----
`timescale 1ns / 1ps

module tb_trial_division_prime_test_core;

  localparam int unsigned NUMBER_W       = tdpt_pkg::NUMBER_W;
  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES    = 2000;
  localparam int unsigned EARLY_WORDS    = 60;
  localparam int unsigned MIDDLE_WORDS   = 40;
  localparam int unsigned CALM_WORDS     = 20;
  localparam int unsigned DRAIN_CYCLES   = 64;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [NUMBER_W-1:0] number    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                is_prime;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned primes;
  int unsigned idle_cycles = 0;

  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit calm     = 1'b0;  // no idling on either side

  logic [NUMBER_W-1:0] corner_words [$];

  trial_division_prime_test_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .number_i   (number),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .is_prime_o (is_prime)
  );

  tdpt_prime_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .number_i    (number),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .is_prime_i  (is_prime),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .primes_o    (primes)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin : receiver
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        span = $urandom_range(1, 20);
        out_stall <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Mix of word classes; large values only where a small factor ends the search early
  function automatic logic [NUMBER_W-1:0] draw_word();
    int unsigned         pick;
    int unsigned         lo_factor;
    int unsigned         hi_factor;
    logic [NUMBER_W-1:0] raw;
    pick = $urandom_range(0, 99);
    raw  = $urandom;
    if (pick < 30) begin
      return NUMBER_W'($urandom_range(0, 4095));
    end else if (pick < 45) begin
      return NUMBER_W'($urandom_range(4096, 65535));
    end else if (pick < 60) begin
      // large even value
      return {1'b0, raw[NUMBER_W-2:1], 1'b0};
    end else if (pick < 70) begin
      // large multiple of three, odd or even
      return NUMBER_W'(3 * $urandom_range(1, 715827882));
    end else if (pick < 85) begin
      return raw | {1'b1, {(NUMBER_W-1){1'b0}}};
    end else begin
      // product of two small factors, squares included
      lo_factor = $urandom_range(2, 255);
      hi_factor = $urandom_range(lo_factor, 255);
      return NUMBER_W'(lo_factor * hi_factor);
    end
  endfunction

  // Offer one word, with a random gap ahead of it, and hold it until accepted
  task automatic offer_word(input logic [NUMBER_W-1:0] value);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int unsigned k;
    // zero, one, smallest primes, squares, sign bit, largest values, one slow prime
    corner_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
                     32'd97, 32'd63001, 32'd65521, 32'd65535, 32'd999983,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h7FFF_FFFE,
                     32'h7FFF_FFFD, 32'h5555_5555};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < corner_words.size(); k++) offer_word(corner_words[k]);
    for (k = 0; k < EARLY_WORDS; k++) offer_word(draw_word());

    // start empty, then hold the output long enough for the core to fill and stall its input
    drain_results();
    hold_req = 1'b1;
    for (k = 0; k < 5; k++) offer_word(NUMBER_W'($urandom_range(0, 255)));

    drain_results();

    for (k = 0; k < MIDDLE_WORDS; k++) offer_word(draw_word());
    calm = 1'b1;
    for (k = 0; k < CALM_WORDS; k++) offer_word(draw_word());

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Tested %0d words, %0d of them prime: corner values, negatives, large composites,",
             checked, primes);
    $display("small and 16-bit values, a long output hold-off and a full drain pause.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- trial_division_prime_test_core.f -----
+incdir+src
src/tdpt_pkg.sv
src/tdpt_rem.sv
src/trial_division_prime_test_core.sv
verif/tdpt_prime_checker.sv
verif/tb_trial_division_prime_test_core.sv
